### src/unicode_case_fold_diacritic_top_macros.svh
// Assertion macros for the case folding block.
// Used by unicode_case_fold_diacritic_top; expects clk and arst_n in scope.
`ifndef UNICODE_CASE_FOLD_DIACRITIC_TOP_MACROS_SVH
`define UNICODE_CASE_FOLD_DIACRITIC_TOP_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define UCF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define UCF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ucf_pkg.sv
// Package for the case folding block: constant tables, mode codes, latencies.
// No dependencies; used by ucf_fold, ucf_strip and the top level.
`default_nettype none
package ucf_pkg;

	localparam int CP_W = 21;

	// Diacritic mode register codes.
	localparam logic [1:0] MODE_KEEP   = 2'd0;
	localparam logic [1:0] MODE_SIMPLE = 2'd1;
	localparam logic [1:0] MODE_ALL    = 2'd2;

	localparam logic [CP_W-1:0] DESERET_LO = 21'd66560;
	localparam logic [CP_W-1:0] DESERET_HI = 21'd66600;

	localparam int FOLD_N = 163;
	localparam int OFF_N  = 77;
	localparam int DIA_N  = 126;

	localparam int FOLD_LVLS = $clog2(FOLD_N);
	localparam int DIA_LVLS  = $clog2(DIA_N);
	localparam int FOLD_LAT  = FOLD_LVLS + 2;
	localparam int DIA_LAT   = DIA_LVLS + 1;
	localparam int TOTAL_LAT = 1 + FOLD_LAT + DIA_LAT;

	localparam logic [15:0] FOLD_START [FOLD_N] = '{
		16'd65, 16'd181, 16'd192, 16'd216, 16'd256, 16'd306,
		16'd313, 16'd330, 16'd376, 16'd377, 16'd383, 16'd385,
		16'd386, 16'd390, 16'd391, 16'd393, 16'd395, 16'd398,
		16'd399, 16'd400, 16'd401, 16'd403, 16'd404, 16'd406,
		16'd407, 16'd408, 16'd412, 16'd413, 16'd415, 16'd416,
		16'd422, 16'd423, 16'd425, 16'd428, 16'd430, 16'd431,
		16'd433, 16'd435, 16'd439, 16'd440, 16'd444, 16'd452,
		16'd453, 16'd455, 16'd456, 16'd458, 16'd459, 16'd478,
		16'd497, 16'd498, 16'd502, 16'd503, 16'd504, 16'd544,
		16'd546, 16'd570, 16'd571, 16'd573, 16'd574, 16'd577,
		16'd579, 16'd580, 16'd581, 16'd582, 16'd837, 16'd880,
		16'd886, 16'd902, 16'd904, 16'd908, 16'd910, 16'd913,
		16'd931, 16'd962, 16'd975, 16'd976, 16'd977, 16'd981,
		16'd982, 16'd984, 16'd1008, 16'd1009, 16'd1012, 16'd1013,
		16'd1015, 16'd1017, 16'd1018, 16'd1021, 16'd1024, 16'd1040,
		16'd1120, 16'd1162, 16'd1216, 16'd1217, 16'd1232, 16'd1329,
		16'd4256, 16'd4295, 16'd4301, 16'd7680, 16'd7835, 16'd7838,
		16'd7840, 16'd7944, 16'd7960, 16'd7976, 16'd7992, 16'd8008,
		16'd8025, 16'd8040, 16'd8072, 16'd8088, 16'd8104, 16'd8120,
		16'd8122, 16'd8124, 16'd8126, 16'd8136, 16'd8140, 16'd8152,
		16'd8154, 16'd8168, 16'd8170, 16'd8172, 16'd8184, 16'd8186,
		16'd8188, 16'd8486, 16'd8490, 16'd8491, 16'd8498, 16'd8544,
		16'd8579, 16'd9398, 16'd11264, 16'd11360, 16'd11362, 16'd11363,
		16'd11364, 16'd11367, 16'd11373, 16'd11374, 16'd11375, 16'd11376,
		16'd11378, 16'd11381, 16'd11390, 16'd11392, 16'd11499, 16'd11506,
		16'd42560, 16'd42624, 16'd42786, 16'd42802, 16'd42873, 16'd42877,
		16'd42878, 16'd42891, 16'd42893, 16'd42896, 16'd42912, 16'd42922,
		16'd65313
	};

	localparam logic [7:0] FOLD_FLAGS [FOLD_N] = '{
		8'd14, 8'd64, 8'd14, 8'd14, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd116, 8'd1, 8'd104, 8'd50,
		8'd1, 8'd44, 8'd0, 8'd42, 8'd0, 8'd32,
		8'd38, 8'd40, 8'd0, 8'd42, 8'd46, 8'd52,
		8'd48, 8'd0, 8'd52, 8'd54, 8'd56, 8'd1,
		8'd60, 8'd0, 8'd60, 8'd0, 8'd60, 8'd0,
		8'd58, 8'd1, 8'd62, 8'd0, 8'd0, 8'd2,
		8'd0, 8'd2, 8'd0, 8'd2, 8'd1, 8'd1,
		8'd2, 8'd1, 8'd122, 8'd134, 8'd1, 8'd110,
		8'd1, 8'd70, 8'd0, 8'd108, 8'd68, 8'd0,
		8'd106, 8'd28, 8'd30, 8'd1, 8'd36, 8'd1,
		8'd0, 8'd18, 8'd16, 8'd26, 8'd24, 8'd14,
		8'd14, 8'd0, 8'd4, 8'd140, 8'd142, 8'd146,
		8'd144, 8'd1, 8'd136, 8'd138, 8'd130, 8'd128,
		8'd0, 8'd152, 8'd0, 8'd110, 8'd34, 8'd14,
		8'd1, 8'd1, 8'd6, 8'd1, 8'd1, 8'd22,
		8'd66, 8'd66, 8'd66, 8'd1, 8'd132, 8'd96,
		8'd1, 8'd150, 8'd150, 8'd150, 8'd150, 8'd150,
		8'd151, 8'd150, 8'd150, 8'd150, 8'd150, 8'd150,
		8'd126, 8'd148, 8'd100, 8'd124, 8'd148, 8'd150,
		8'd120, 8'd150, 8'd118, 8'd152, 8'd112, 8'd114,
		8'd148, 8'd98, 8'd92, 8'd94, 8'd12, 8'd8,
		8'd0, 8'd10, 8'd22, 8'd0, 8'd88, 8'd102,
		8'd90, 8'd1, 8'd84, 8'd86, 8'd80, 8'd82,
		8'd0, 8'd0, 8'd78, 8'd1, 8'd1, 8'd0,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd76,
		8'd1, 8'd0, 8'd74, 8'd1, 8'd1, 8'd72,
		8'd14
	};

	localparam logic [7:0] FOLD_LEN [FOLD_N] = '{
		8'd26, 8'd1, 8'd23, 8'd7, 8'd48, 8'd6,
		8'd16, 8'd46, 8'd1, 8'd6, 8'd1, 8'd1,
		8'd4, 8'd1, 8'd1, 8'd2, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd6,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd2, 8'd4, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd18, 8'd18,
		8'd1, 8'd4, 8'd1, 8'd1, 8'd40, 8'd1,
		8'd18, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd10, 8'd1, 8'd4,
		8'd1, 8'd1, 8'd3, 8'd1, 8'd2, 8'd17,
		8'd9, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd24, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd3, 8'd16, 8'd32,
		8'd34, 8'd54, 8'd1, 8'd14, 8'd88, 8'd38,
		8'd38, 8'd1, 8'd1, 8'd150, 8'd1, 8'd1,
		8'd96, 8'd8, 8'd6, 8'd8, 8'd8, 8'd6,
		8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd2,
		8'd2, 8'd1, 8'd1, 8'd4, 8'd1, 8'd2,
		8'd2, 8'd2, 8'd2, 8'd1, 8'd2, 8'd2,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd16,
		8'd1, 8'd26, 8'd47, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd6, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd2, 8'd100, 8'd4, 8'd1,
		8'd46, 8'd24, 8'd14, 8'd62, 8'd4, 8'd1,
		8'd10, 8'd1, 8'd1, 8'd4, 8'd10, 8'd1,
		8'd26
	};

	localparam logic [15:0] FOLD_OFF [OFF_N] = '{
		16'd1, 16'd2, 16'd8, 16'd15, 16'd16, 16'd26, 16'd28, 16'd32,
		16'd37, 16'd38, 16'd40, 16'd48, 16'd63, 16'd64, 16'd69, 16'd71,
		16'd79, 16'd80, 16'd116, 16'd202, 16'd203, 16'd205, 16'd206, 16'd207,
		16'd209, 16'd210, 16'd211, 16'd213, 16'd214, 16'd217, 16'd218, 16'd219,
		16'd775, 16'd7264, 16'd10792, 16'd10795, 16'd23228, 16'd23256, 16'd30204, 16'd54721,
		16'd54753, 16'd54754, 16'd54756, 16'd54787, 16'd54793, 16'd54809, 16'd57153, 16'd57274,
		16'd57921, 16'd58019, 16'd58363, 16'd61722, 16'd65268, 16'd65341, 16'd65373, 16'd65406,
		16'd65408, 16'd65410, 16'd65415, 16'd65424, 16'd65436, 16'd65439, 16'd65450, 16'd65462,
		16'd65472, 16'd65476, 16'd65478, 16'd65480, 16'd65482, 16'd65488, 16'd65506, 16'd65511,
		16'd65514, 16'd65521, 16'd65527, 16'd65528, 16'd65529
	};

	// Each key holds the first point shifted up by three and the count minus one.
	localparam logic [15:0] DIA_KEY [DIA_N] = '{
		16'd0, 16'd1797, 16'd1848, 16'd1859, 16'd1891, 16'd1928, 16'd1940, 16'd1995,
		16'd2024, 16'd2040, 16'd2060, 16'd2110, 16'd2168, 16'd2206, 16'd2264, 16'd2286,
		16'd2344, 16'd2383, 16'd2472, 16'd2488, 16'd2516, 16'd2596, 16'd2668, 16'd2732,
		16'd2782, 16'd2842, 16'd2894, 16'd2954, 16'd2984, 16'd3000, 16'd3028, 16'd3336,
		16'd3456, 16'd3696, 16'd3712, 16'd3728, 16'd3744, 16'd3766, 16'd3832, 16'd3896,
		16'd3912, 16'd3928, 16'd3944, 16'd3968, 16'd4008, 16'd4040, 16'd4056, 16'd4106,
		16'd4138, 16'd4170, 16'd4202, 16'd4234, 16'd4266, 16'd4296, 16'd4312, 16'd4344,
		16'd4408, 16'd4424, 16'd4442, 16'd4472, 16'd4488, 16'd4504, 16'd6148, 16'd6198,
		16'd6264, 16'd6280, 16'd6360, 16'd6429, 16'd6505, 16'd6529, 16'd61448, 16'd61468,
		16'd61512, 16'd61534, 16'd61592, 16'd61610, 16'd61642, 16'd61672, 16'd61688, 16'd61704,
		16'd61726, 16'd61784, 16'd61800, 16'd61816, 16'd61836, 16'd61880, 16'd61896, 16'd61914,
		16'd61948, 16'd61998, 16'd62062, 16'd62122, 16'd62154, 16'd62184, 16'd62200, 16'd62218,
		16'd62252, 16'd62302, 16'd62364, 16'd62410, 16'd62442, 16'd62478, 16'd62536, 16'd62554,
		16'd62584, 16'd62604, 16'd62640, 16'd62648, 16'd62656, 16'd62664, 16'd62730, 16'd62766,
		16'd62830, 16'd62890, 16'd62924, 16'd62974, 16'd63032, 16'd63050, 16'd63082, 16'd63118,
		16'd63182, 16'd63242, 16'd63274, 16'd63310, 16'd63368, 16'd63390
	};

	// Bare ASCII letter; the top bit marks a complex entry.
	localparam logic [7:0] DIA_CHAR [DIA_N] = '{
		8'h00, 8'h61, 8'h63, 8'h65, 8'h69, 8'h6e,
		8'h6f, 8'h75, 8'h79, 8'h79, 8'h61, 8'h63,
		8'h64, 8'h65, 8'h65, 8'h67, 8'h68, 8'h69,
		8'h6a, 8'h6b, 8'h6c, 8'h6e, 8'h6f, 8'h72,
		8'h73, 8'h74, 8'h75, 8'h75, 8'h77, 8'h79,
		8'h7a, 8'h6f, 8'h75, 8'h61, 8'h69, 8'h6f,
		8'h75, 8'hf5, 8'he1, 8'h67, 8'h6b, 8'h6f,
		8'hef, 8'h6a, 8'h67, 8'h6e, 8'he1, 8'h61,
		8'h65, 8'h69, 8'h6f, 8'h72, 8'h75, 8'h73,
		8'h74, 8'h68, 8'h61, 8'h65, 8'hef, 8'h6f,
		8'hef, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h61, 8'h62,
		8'he3, 8'h64, 8'h64, 8'he5, 8'h65, 8'he5,
		8'h66, 8'h67, 8'h68, 8'h68, 8'h69, 8'he9,
		8'h6b, 8'h6c, 8'hec, 8'h6c, 8'h6d, 8'h6e,
		8'hef, 8'h70, 8'h72, 8'hf2, 8'h72, 8'h73,
		8'hf3, 8'h74, 8'h75, 8'hf5, 8'h76, 8'h77,
		8'h77, 8'h78, 8'h79, 8'h7a, 8'h68, 8'h74,
		8'h77, 8'h79, 8'h61, 8'he1, 8'he1, 8'he1,
		8'h65, 8'he5, 8'he5, 8'h69, 8'h6f, 8'hef,
		8'hef, 8'hef, 8'h75, 8'hf5, 8'hf5, 8'h79
	};

endpackage
`default_nettype wire

### src/unicode_case_fold_diacritic_top.sv
// Top level of the case folding block: input register, fold and strip pipelines.
// Depends on ucf_pkg, ucf_fold, ucf_strip and the assertion macro header.
//
// Usage:
// A request is taken at a rising edge with start high and busy low. busy is
// always low: the pipeline takes one code point every cycle, with no gaps.
// Each request gives exactly one result on folded_point, shown for one cycle
// with done high. Results keep request order. The pipeline is made of the two
// binary searches, one level a stage: eight levels over the case range table,
// seven over the diacritic table, plus the input register, the range lookup,
// the offset add and the replacement stage.
// The receiver cannot hold a result off, so nothing in the pipeline stalls.
// The diacritic mode register is written over cfg_valid, cfg_ready and
// cfg_data; cfg_ready is always high. Write it only while no request is in
// flight. Reset clears all valid bits and sets the mode to remove simple
// diacritics; the block takes requests in the first cycle after reset.
`default_nettype none
`include "unicode_case_fold_diacritic_top_macros.svh"
module unicode_case_fold_diacritic_top
	import ucf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [CP_W-1:0] code_point,
	output logic            done,
	output logic [CP_W-1:0] folded_point,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_data
);

	logic [1:0]      mode_q;
	logic            v_s1;
	logic [CP_W-1:0] c_s1;
	logic            fold_v;
	logic [CP_W-1:0] fold_r;
	logic            fold_bmp;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Diacritic mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SIMPLE;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= code_point;
	end

	ucf_fold u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v_s1),
		.in_c    (c_s1),
		.out_v   (fold_v),
		.out_r   (fold_r),
		.out_bmp (fold_bmp)
	);

	ucf_strip u_strip (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode_q),
		.in_v   (fold_v),
		.in_r   (fold_r),
		.in_bmp (fold_bmp),
		.out_v  (done),
		.out_r  (folded_point)
	);

	// Every request comes out with done high once it has passed the pipeline.
	`UCF_ASSERT_IMP(a_latency, start && !busy, ##TOTAL_LAT done, "result missing at latency")
	// Points below the capital letters pass through unchanged.
	`UCF_ASSERT_IMP(a_low_ascii, start && !busy && (code_point < CP_W'(65)), ##TOTAL_LAT (folded_point == $past(code_point, TOTAL_LAT)), "low ASCII point altered")
	// A configuration write lands in the mode register.
	`UCF_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready, mode_q == $past(cfg_data), "mode write lost")

endmodule
`default_nettype wire

### src/ucf_fold.sv
// Case folding pipeline: binary search of the range table, one level a stage.
// Depends on ucf_pkg for the range and offset tables.
`default_nettype none
module ucf_fold
	import ucf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_v,
	input  logic [CP_W-1:0] in_c,
	output logic            out_v,
	output logic [CP_W-1:0] out_r,
	output logic            out_bmp
);

	localparam int IW = FOLD_LVLS;

	logic            v_s   [FOLD_LVLS+1];
	logic [CP_W-1:0] c_s   [FOLD_LVLS+1];
	logic [IW-1:0]   idx_s [FOLD_LVLS+1];

	assign v_s[0]   = in_v;
	assign c_s[0]   = in_c;
	assign idx_s[0] = '0;

	// One search level per stage, most significant index bit first.
	for (genvar l = 0; l < FOLD_LVLS; l++) begin : g_lvl
		localparam int B = FOLD_LVLS - 1 - l;
		logic [IW-1:0] probe;
		logic          take;
		assign probe = idx_s[l] | (IW'(1) << B);
		assign take  = (int'(probe) < FOLD_N) && (FOLD_START[probe] <= c_s[l][15:0]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[l+1] <= 1'b0;
			end else begin
				v_s[l+1] <= v_s[l];
			end
		end

		always_ff @(posedge clk) begin
			c_s[l+1]   <= c_s[l];
			idx_s[l+1] <= take ? probe : idx_s[l];
		end
	end

	// Entry lookup: decide whether the point lies in the range and fetch its offset.
	logic [IW-1:0]   hit;
	logic [15:0]     st;
	logic [7:0]      fl;
	logic [16:0]     range_end;
	logic [6:0]      oi;
	logic            in_range;
	logic [15:0]     off;
	logic            v_sa;
	logic [CP_W-1:0] c_sa;
	logic [15:0]     off_sa;

	assign hit       = idx_s[FOLD_LVLS];
	assign st        = FOLD_START[hit];
	assign fl        = FOLD_FLAGS[hit];
	assign range_end = {1'b0, st} + {9'd0, FOLD_LEN[hit]};
	assign oi        = fl[7:1];
	assign in_range  = (c_s[FOLD_LVLS][15:0] >= st)
		&& ({1'b0, c_s[FOLD_LVLS][15:0]} < range_end)
		&& !(fl[0] & (st[0] ^ c_s[FOLD_LVLS][0]));
	assign off       = (in_range && (int'(oi) < OFF_N)) ? FOLD_OFF[oi] : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
		end else begin
			v_sa <= v_s[FOLD_LVLS];
		end
	end

	always_ff @(posedge clk) begin
		c_sa   <= c_s[FOLD_LVLS];
		off_sa <= off;
	end

	// Final stage: choose between ASCII, basic plane, Deseret and pass-through.
	logic [15:0]     bmp_r;
	logic            is_bmp;
	logic [CP_W-1:0] r_next;

	assign bmp_r  = c_sa[15:0] + off_sa;
	assign is_bmp = (c_sa >= CP_W'(128)) && (c_sa <= CP_W'(16'hFFFF));

	always_comb begin
		r_next = c_sa;
		if (c_sa < CP_W'(128)) begin
			if ((c_sa >= CP_W'(65)) && (c_sa <= CP_W'(90))) begin
				r_next = c_sa + CP_W'(32);
			end
		end else if (is_bmp) begin
			r_next = {5'd0, bmp_r};
		end else if ((c_sa >= DESERET_LO) && (c_sa < DESERET_HI)) begin
			r_next = c_sa + CP_W'(40);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else begin
			out_v <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		out_r   <= r_next;
		out_bmp <= is_bmp;
	end

endmodule
`default_nettype wire

### src/ucf_strip.sv
// Diacritic removal pipeline: binary search of the diacritic ranges, then replace.
// Depends on ucf_pkg for the key and letter tables and the mode codes.
`default_nettype none
module ucf_strip
	import ucf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      mode,
	input  logic            in_v,
	input  logic [CP_W-1:0] in_r,
	input  logic            in_bmp,
	output logic            out_v,
	output logic [CP_W-1:0] out_r
);

	localparam int IW = DIA_LVLS;

	logic            v_s   [DIA_LVLS+1];
	logic [CP_W-1:0] r_s   [DIA_LVLS+1];
	logic            bmp_s [DIA_LVLS+1];
	logic [IW-1:0]   idx_s [DIA_LVLS+1];

	assign v_s[0]   = in_v;
	assign r_s[0]   = in_r;
	assign bmp_s[0] = in_bmp;
	assign idx_s[0] = '0;

	// One search level per stage over the keys, compared with the point's key.
	for (genvar l = 0; l < DIA_LVLS; l++) begin : g_lvl
		localparam int B = DIA_LVLS - 1 - l;
		logic [IW-1:0] probe;
		logic [18:0]   key;
		logic          take;
		assign key   = {r_s[l][15:0], 3'b111};
		assign probe = idx_s[l] | (IW'(1) << B);
		assign take  = (int'(probe) < DIA_N) && ({3'd0, DIA_KEY[probe]} <= key);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[l+1] <= 1'b0;
			end else begin
				v_s[l+1] <= v_s[l];
			end
		end

		always_ff @(posedge clk) begin
			r_s[l+1]   <= r_s[l];
			bmp_s[l+1] <= bmp_s[l];
			idx_s[l+1] <= take ? probe : idx_s[l];
		end
	end

	// Replacement: the bare letter when the range covers the point and the mode allows.
	logic [IW-1:0]   hit;
	logic [7:0]      ch;
	logic [15:0]     k;
	logic [16:0]     last;
	logic [CP_W-1:0] rv;
	logic [CP_W-1:0] r_next;

	assign hit  = idx_s[DIA_LVLS];
	assign ch   = DIA_CHAR[hit];
	assign k    = DIA_KEY[hit];
	assign last = {4'd0, k[15:3]} + {14'd0, k[2:0]};
	assign rv   = r_s[DIA_LVLS];

	always_comb begin
		r_next = rv;
		if (bmp_s[DIA_LVLS] && (mode != MODE_KEEP)) begin
			if (((mode == MODE_ALL) || !ch[7]) && (rv <= {4'd0, last})) begin
				r_next = {14'd0, ch[6:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else begin
			out_v <= v_s[DIA_LVLS];
		end
	end

	always_ff @(posedge clk) begin
		out_r <= r_next;
	end

endmodule
`default_nettype wire

### tb/unicode_case_fold_diacritic_top_tb.sv
// Self-checking testbench for the case folding block with diacritic removal.
// Depends on ucf_pkg and unicode_case_fold_diacritic_top; drives code points and
// checks every folded result against fixed values or a local fold and strip model.
`default_nettype none
module unicode_case_fold_diacritic_top_tb;
	import ucf_pkg::*;

	localparam int PERIOD_HALF = 5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 384;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [CP_W-1:0] code_point;
	logic            done;
	logic [CP_W-1:0] folded_point;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [1:0]      cfg_data;

	logic [1:0]      mode_shadow;
	logic [CP_W-1:0] pending_folds[$];
	int              fail_count;
	int              cycle_count;
	int              idle_pct;

	// Directed rows: point, and the expected fold where it is obvious (-1 = predict).
	typedef struct {
		int point;
		int fixed;
	} dir_row_t;

	localparam int DIR_N = 22;
	dir_row_t dir_rows[DIR_N] = '{
		'{0, 0}, '{65, 97}, '{90, 122}, '{64, 64}, '{91, 91}, '{127, 127},
		'{128, -1}, '{192, -1}, '{201, -1}, '{256, -1}, '{257, -1}, '{913, -1},
		'{7838, -1}, '{8486, -1}, '{65313, -1}, '{65535, -1}, '{768, -1},
		'{65536, 65536}, '{66560, 66600}, '{66599, 66639}, '{66600, 66600},
		'{2097151, 2097151}
	};

	unicode_case_fold_diacritic_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.code_point  (code_point),
		.done        (done),
		.folded_point(folded_point),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #PERIOD_HALF clk = ~clk;

	// Strip a diacritic from a basic-plane point when the table covers it.
	function automatic logic [CP_W-1:0] strip_mark(logic [CP_W-1:0] v, bit take_complex);
		logic [18:0] key;
		int          hit;
		int          last_pt;
		key = {v[15:0], 3'b111};
		hit = 0;
		for (int i = 0; i < DIA_N; i++) begin
			if (key >= {3'b000, DIA_KEY[i]}) hit = i;
		end
		if (!take_complex && DIA_CHAR[hit][7]) return v;
		last_pt = int'(DIA_KEY[hit][15:3]) + int'(DIA_KEY[hit][2:0]);
		if (int'(v) > last_pt) return v;
		return {14'd0, DIA_CHAR[hit][6:0]};
	endfunction

	// Fold one code point under the current mode.
	function automatic logic [CP_W-1:0] fold_point(logic [CP_W-1:0] c, logic [1:0] mode);
		logic [CP_W-1:0] r;
		int              hit;
		int              st;
		int              fl;
		r = c;
		if (c < 21'h80) begin
			if (c >= 21'd65 && c <= 21'd90) r = c + 21'd32;
		end else if (c <= 21'hFFFF) begin
			hit = 0;
			for (int i = 0; i < FOLD_N; i++) begin
				if (int'(FOLD_START[i]) <= int'(c)) hit = i;
			end
			st = FOLD_START[hit];
			fl = FOLD_FLAGS[hit];
			if (int'(c) >= st && int'(c) < st + int'(FOLD_LEN[hit])
					&& (fl & 1 & (st ^ int'(c))) == 0 && (fl >> 1) < OFF_N)
				r = {5'd0, c[15:0] + FOLD_OFF[fl >> 1]};
			if (mode != MODE_KEEP) r = strip_mark(r, mode == MODE_ALL);
		end else if (c >= DESERET_LO && c < DESERET_HI) begin
			r = c + 21'd40;
		end
		return r;
	endfunction

	// Random point, weighted toward the tables and the letters.
	function automatic logic [CP_W-1:0] pick_point();
		case ($urandom_range(0, 7))
			0: return 21'($urandom_range(0, 127));
			1, 2: return 21'($urandom_range(128, 1400));
			3: return 21'($urandom_range(7680, 11520));
			4: return 21'($urandom_range(42560, 65535));
			5: return 21'($urandom_range(66550, 66610));
			default: return 21'($urandom);
		endcase
	endfunction

	// Issue one request, idling at random beforehand.
	task automatic send_point(logic [CP_W-1:0] c, int fixed);
		while ($urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		code_point <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_folds.push_back(fixed >= 0 ? 21'(fixed) : fold_point(c, mode_shadow));
	endtask

	// Wait until the pipeline is empty, then past its latency.
	task automatic drain();
		start <= 1'b0;
		while (pending_folds.size() != 0) @(posedge clk);
		repeat (TOTAL_LAT + 2) @(posedge clk);
	endtask

	task automatic write_mode(logic [1:0] m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mode_shadow = m;
	endtask

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_folds.size() == 0) begin
				$error("folded_point: no request pending, got %0d", folded_point);
				fail_count++;
			end else begin
				if (folded_point !== pending_folds[0]) begin
					$error("folded_point: expected %0d, got %0d",
						pending_folds[0], folded_point);
					fail_count++;
				end
				void'(pending_folds.pop_front());
			end
		end
	end

	// Runaway guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [1:0] phase_modes[4];
		int         phase_idle[4];
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		code_point = '0;
		cfg_valid = 1'b0;
		cfg_data = MODE_SIMPLE;
		mode_shadow = MODE_SIMPLE;
		fail_count = 0;
		cycle_count = 0;
		idle_pct = 0;
		phase_modes = '{MODE_KEEP, MODE_ALL, 2'd3, MODE_SIMPLE};
		phase_idle = '{0, 82, 35, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset mode, then with diacritics kept and all removed.
		for (int m = 0; m < 3; m++) begin
			if (m == 1) write_mode(MODE_KEEP);
			if (m == 2) write_mode(MODE_ALL);
			for (int i = 0; i < DIR_N; i++)
				send_point(21'(dir_rows[i].point), dir_rows[i].fixed);
			drain();
		end

		// Random phases with different modes and idle rates.
		for (int p = 0; p < 4; p++) begin
			write_mode(phase_modes[p]);
			idle_pct = phase_idle[p];
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
				send_point(pick_point(), -1);
				if (i == 40) drain();
			end
			drain();
		end

		if (fail_count == 0 && pending_folds.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
